[rtl/core/dfa_pkg.sv]
// shared types and constants for the decimal float arithmetic unit
// no dependencies
package dfa_pkg;
	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DIV0  = 2'd1;
	localparam logic [1:0] ST_EWRAP = 2'd2;
	localparam logic [1:0] ST_MWRAP = 2'd3;

	localparam logic [63:0] ADD_SCALE_LIMIT = 64'd10000000000000000;
	localparam logic [63:0] MUL_DIGIT_MAX   = 64'd999999999;
	localparam logic [63:0] DIV_SCALE_LIMIT = 64'd999999999999999999;
	localparam logic [63:0] TIMES_TEN_MAX   = 64'd1844674407370955161;
	localparam logic signed [9:0] ADD_EXP_FLOOR = -10'sd100;
	localparam logic signed [9:0] DIV_EXP_FLOOR = -10'sd99;

	// operation codes for the shared decimal shifter
	typedef enum logic [1:0] {
		SH_MUL10 = 2'd0,
		SH_DIV10 = 2'd1,
		SH_RND10 = 2'd2
	} sh_op_t;

	// value times ten, truncated to 64 bits
	function automatic logic [63:0] mul10(input logic [63:0] m);
		mul10 = {m[60:0], 3'b000} + {m[62:0], 1'b0};
	endfunction
endpackage

[rtl/core/dfa_div10.sv]
// shared decimal shift unit: times ten combinationally, divide by ten and
// round-divide by ten as a four-pass reciprocal multiply; depends on dfa_pkg
module dfa_div10 import dfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sh_op_t      op,
	input  logic [63:0] din,
	input  logic        start,
	output logic [63:0] dout,
	output logic        wrap,
	output logic        busy,
	output logic        done
);
	// ceil(2^66 / 5), split into halves for one 32x32 multiplier
	localparam logic [31:0] RECIP_LO = 32'hCCCCCCCD;
	localparam logic [31:0] RECIP_HI = 32'hCCCCCCCC;

	logic [64:0]  num;
	logic [63:0]  y_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         run_q;
	logic         done_q;
	logic [31:0]  mul_a, mul_b;
	logic [63:0]  part;
	logic [127:0] part_sh;

	assign num = (op == SH_RND10) ? ({1'b0, din} + 65'd5) : {1'b0, din};

	// pass 0: lo*lo, 1: hi*lo, 2: lo*hi, 3: hi*hi
	assign mul_a = cnt_q[0] ? y_q[63:32] : y_q[31:0];
	assign mul_b = cnt_q[1] ? RECIP_HI : RECIP_LO;
	assign part  = mul_a * mul_b;

	always_comb begin
		case (cnt_q)
			2'd0:    part_sh = {64'd0, part};
			2'd3:    part_sh = {part, 64'd0};
			default: part_sh = {32'd0, part, 32'd0};
		endcase
	end

	// floor(num / 10) = floor(floor(num / 2) / 5), exact for 64-bit values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			y_q    <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == 2'd3) && !start;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 2'd0;
				y_q   <= num[64:1];
				acc_q <= '0;
			end else if (run_q) begin
				acc_q <= acc_q + part_sh;
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					run_q <= 1'b0;
			end
		end
	end

	assign busy = run_q || done_q;
	assign done = done_q;

	always_comb begin
		dout = 64'd0;
		wrap = 1'b0;
		case (op)
			SH_MUL10: begin
				dout = mul10(din);
				wrap = din > TIMES_TEN_MAX;
			end
			SH_DIV10, SH_RND10: begin
				dout = {2'b00, acc_q[127:66]};
			end
			default: begin
				dout = din;
			end
		endcase
	end
endmodule

[rtl/core/dfa_udiv.sv]
// radix-2 restoring unsigned 64-bit divider, one bit per cycle
// depends on dfa_pkg
module dfa_udiv import dfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quot
);
	logic [63:0] q_q;
	logic [64:0] r_q;
	logic [63:0] d_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;

	assign trial = {r_q[63:0], q_q[63]} - {1'b0, d_q};
	assign quot  = q_q;
	assign done  = busy_q && (cnt_q == 7'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd64;
			q_q    <= dividend;
			r_q    <= '0;
			d_q    <= divisor;
		end else if (busy_q) begin
			if (cnt_q == 7'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 7'd1;
				if (!trial[64]) begin
					r_q <= trial;
					q_q <= {q_q[62:0], 1'b1};
				end else begin
					r_q <= {r_q[63:0], q_q[63]};
					q_q <= {q_q[62:0], 1'b0};
				end
			end
		end
	end
endmodule

[rtl/core/decimal_float_arith_unit.sv]
// top level of the decimal float arithmetic unit: sequencer and datapath
// depends on dfa_pkg, dfa_div10, dfa_udiv
//
// Each operand is a signed 64-bit mantissa times ten to a signed 8-bit
// exponent. A request on the input channel (valid/stall) carries cmd and
// both operands; one result leaves on the output channel (valid/stall).
// The unit works on one request at a time: input stall is high from the
// accepting edge until the result has been taken downstream, and the next
// request can be accepted the cycle after that.
// Latency is data dependent: a times-ten step through the shared decimal
// shift unit is combinational, while a divide-by-ten or rounding step runs
// the unit's one 32x32 multiplier over four passes. An add or subtract
// scales the larger operand up by ten, then aligns the smaller one by
// dividing or multiplying it by ten once per unit of exponent difference,
// so close exponents finish sooner. A multiply rounds each operand by up
// to ten steps. A divide scales the dividend (up to about 230 steps for a
// zero dividend, 18 otherwise) and then waits for the bit-serial divider.
// The result is held in an output register until it is taken; while the
// receiver stalls nothing else happens. Reset clears the sequencer and
// the output valid; no request is lost across it other than one in flight.
module decimal_float_arith_unit import dfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic signed [63:0] a_mant,
	input  logic signed [7:0]  a_exp,
	input  logic signed [63:0] b_mant,
	input  logic signed [7:0]  b_exp,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] res_mant,
	output logic signed [7:0]  res_exp,
	output logic [1:0]         status
);
	typedef enum logic [3:0] {
		S_IDLE, S_ADD_SCALE, S_ADD_DOWN, S_ADD_UP, S_ADD_SUM,
		S_MUL_RA, S_MUL_RB, S_MUL_PROD, S_MUL_SUM,
		S_DIV_SCALE, S_DIV_START, S_DIV_WAIT, S_OUT
	} state_t;

	state_t state_q;
	logic [63:0] ma_q, mb_q;        // magnitudes
	logic na_q, nb_q;
	logic signed [9:0] ea_q, eb_q;
	logic big_b_q;                  // b is the larger operand
	logic mwrap_q;
	logic [65:0] rmag_q;
	logic rneg_q;
	logic signed [9:0] rexp_q;
	logic out_valid_q;
	logic [63:0] res_mant_q;
	logic [7:0] res_exp_q;
	logic [1:0] status_q;

	sh_op_t sh_op;
	logic [63:0] sh_in, sh_out;
	logic sh_wrap;
	logic sh_start, sh_busy, sh_done;
	logic div_start, div_done;
	logic [63:0] div_q;

	dfa_div10 u_sh (
		.clk(clk), .arst_n(arst_n), .op(sh_op), .din(sh_in), .start(sh_start),
		.dout(sh_out), .wrap(sh_wrap), .busy(sh_busy), .done(sh_done)
	);
	dfa_udiv u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(ma_q), .divisor(mb_q), .done(div_done), .quot(div_q)
	);

	logic [63:0] big_m, sml_m;
	logic signed [9:0] big_e, sml_e;
	logic [63:0] a_mag, b_mag;
	logic b_neg;
	logic a_big;
	logic [63:0] pend_m;
	logic pend_n;
	logic signed [9:0] pend_e;
	logic pend_mw;
	logic pend_ew;

	assign a_mag = a_mant[63] ? 64'd0 - a_mant : a_mant;
	assign b_mag = b_mant[63] ? 64'd0 - b_mant : b_mant;
	assign b_neg = b_mant[63] ^ (cmd == CMD_SUB);
	assign a_big = (a_exp > b_exp) || (a_exp == b_exp && a_mag > b_mag);
	assign big_m = big_b_q ? mb_q : ma_q;
	assign sml_m = big_b_q ? ma_q : mb_q;
	assign big_e = big_b_q ? eb_q : ea_q;
	assign sml_e = big_b_q ? ea_q : eb_q;

	always_comb begin
		sh_op = SH_MUL10;
		sh_in = big_m;
		case (state_q)
			S_ADD_DOWN: begin
				sh_op = SH_DIV10;
				sh_in = sml_m;
			end
			S_ADD_UP:    sh_in = sml_m;
			S_MUL_RA: begin
				sh_op = SH_RND10;
				sh_in = ma_q;
			end
			S_MUL_RB: begin
				sh_op = SH_RND10;
				sh_in = mb_q;
			end
			S_DIV_SCALE: sh_in = ma_q;
			default: sh_in = big_m;
		endcase
	end

	// launch a divide-by-ten or rounding step whenever a dividing loop still has work and the shifter is idle
	assign sh_start = !sh_busy && (
		(state_q == S_ADD_DOWN && sml_e < big_e) ||
		(state_q == S_MUL_RA && ma_q > MUL_DIGIT_MAX) ||
		(state_q == S_MUL_RB && mb_q > MUL_DIGIT_MAX));

	assign div_start = (state_q == S_DIV_START);

	// final packing of sign, magnitude and exponent
	always_comb begin
		pend_m  = 64'd0 - rmag_q[63:0];
		pend_n  = rneg_q && (rmag_q != 66'd0);
		pend_mw = mwrap_q || (rmag_q[65:64] != 2'b00) ||
			(pend_n ? rmag_q[63:0] > 64'h8000000000000000 : rmag_q[63]);
		pend_e  = rexp_q;
		pend_ew = (rexp_q < -10'sd128) || (rexp_q > 10'sd127);
		if (!pend_n)
			pend_m = rmag_q[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ma_q    <= a_mag;
						mb_q    <= b_mag;
						na_q    <= a_mant[63];
						nb_q    <= (cmd == CMD_SUB || cmd == CMD_ADD) ? b_neg : b_mant[63];
						ea_q    <= 10'(a_exp);
						eb_q    <= 10'(b_exp);
						big_b_q <= !a_big;
						mwrap_q <= 1'b0;
						case (cmd_t'(cmd))
							CMD_ADD, CMD_SUB: state_q <= S_ADD_SCALE;
							CMD_MUL: state_q <= S_MUL_RA;
							default: begin
								if (b_mag == 64'd0) begin
									res_mant_q  <= '0;
									res_exp_q   <= '0;
									status_q    <= ST_DIV0;
									out_valid_q <= 1'b1;
									state_q     <= S_OUT;
								end else begin
									state_q <= S_DIV_SCALE;
								end
							end
						endcase
					end
				end
				S_ADD_SCALE: begin
					if (big_m < ADD_SCALE_LIMIT && big_e > ADD_EXP_FLOOR) begin
						if (big_b_q) begin
							mb_q <= sh_out;
							eb_q <= eb_q - 10'sd1;
						end else begin
							ma_q <= sh_out;
							ea_q <= ea_q - 10'sd1;
						end
					end else begin
						state_q <= S_ADD_DOWN;
					end
				end
				S_ADD_DOWN: begin
					if (sml_e < big_e) begin
						if (sh_done) begin
							if (big_b_q) begin
								ma_q <= sh_out;
								ea_q <= ea_q + 10'sd1;
							end else begin
								mb_q <= sh_out;
								eb_q <= eb_q + 10'sd1;
							end
						end
					end else begin
						state_q <= S_ADD_UP;
					end
				end
				S_ADD_UP: begin
					if (sml_e > big_e) begin
						if (sh_wrap)
							mwrap_q <= 1'b1;
						if (big_b_q) begin
							ma_q <= sh_out;
							ea_q <= ea_q - 10'sd1;
						end else begin
							mb_q <= sh_out;
							eb_q <= eb_q - 10'sd1;
						end
					end else begin
						state_q <= S_ADD_SUM;
					end
				end
				S_ADD_SUM: begin
					rexp_q <= big_e;
					if (na_q == nb_q) begin
						rmag_q <= {2'b00, ma_q} + {2'b00, mb_q};
						rneg_q <= na_q;
					end else if (ma_q >= mb_q) begin
						rmag_q <= {2'b00, ma_q - mb_q};
						rneg_q <= na_q;
					end else begin
						rmag_q <= {2'b00, mb_q - ma_q};
						rneg_q <= nb_q;
					end
					state_q <= S_MUL_SUM;
				end
				S_MUL_RA: begin
					if (ma_q > MUL_DIGIT_MAX) begin
						if (sh_done) begin
							ma_q <= sh_out;
							ea_q <= ea_q + 10'sd1;
						end
					end else begin
						state_q <= S_MUL_RB;
					end
				end
				S_MUL_RB: begin
					if (mb_q > MUL_DIGIT_MAX) begin
						if (sh_done) begin
							mb_q <= sh_out;
							eb_q <= eb_q + 10'sd1;
						end
					end else begin
						state_q <= S_MUL_PROD;
					end
				end
				S_MUL_PROD: begin
					// both below 2^30, so one narrow multiply
					rmag_q <= 66'(ma_q[29:0] * mb_q[29:0]);
					rneg_q <= na_q ^ nb_q;
					rexp_q <= ea_q + eb_q;
					state_q <= S_MUL_SUM;
				end
				S_MUL_SUM: begin
					res_mant_q  <= pend_m;
					res_exp_q   <= pend_e[7:0];
					status_q    <= pend_mw ? ST_MWRAP : (pend_ew ? ST_EWRAP : ST_OK);
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_DIV_SCALE: begin
					if (ma_q < DIV_SCALE_LIMIT && ea_q > DIV_EXP_FLOOR) begin
						ma_q <= sh_out;
						ea_q <= ea_q - 10'sd1;
					end else begin
						state_q <= S_DIV_START;
					end
				end
				S_DIV_START: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						rmag_q  <= {2'b00, div_q};
						rneg_q  <= na_q ^ nb_q;
						rexp_q  <= ea_q - eb_q;
						state_q <= S_MUL_SUM;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign res_mant  = res_mant_q;
	assign res_exp   = res_exp_q;
	assign status    = status_q;
endmodule

[sim/tb_top.sv]
// self-checking testbench for decimal_float_arith_unit
// depends on dfa_pkg and the unit's rtl; predicts every result and compares field by field

module tb_top;
	import dfa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [63:0] mant;
		logic signed [7:0]  expo;
		logic [1:0]         st;
	} dec_res_t;

	localparam logic [63:0] MIN_MANT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_MANT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] WRAP_LIM = 64'hFFFF_FFFF_FFFF_FFFF / 64'd10;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	cmd_t               cmd;
	logic signed [63:0] a_mant;
	logic signed [7:0]  a_exp;
	logic signed [63:0] b_mant;
	logic signed [7:0]  b_exp;
	logic               out_valid;
	logic               out_stall;
	logic signed [63:0] res_mant;
	logic signed [7:0]  res_exp;
	logic [1:0]         status;

	dec_res_t pending_results[$];
	int       n_errors;
	int       n_checked;
	int       n_sent;
	int       n_wraps;
	int       burst_left;
	int       hold_off;
	int       stall_mode;
	int       stall_phase;

	decimal_float_arith_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .a_mant(a_mant), .a_exp(a_exp), .b_mant(b_mant), .b_exp(b_exp),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_mant(res_mant), .res_exp(res_exp), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// magnitude of a raw mantissa, and a signed mantissa from sign and magnitude
	function automatic logic [63:0] magnitude(input logic [63:0] raw);
		return raw[63] ? (64'd0 - raw) : raw;
	endfunction

	function automatic logic [63:0] signed_mant(input logic neg, input logic [63:0] mag,
		inout logic mwrap);
		if (mag == 64'd0)
			return 64'd0;
		if (neg) begin
			if (mag > MIN_MANT)
				mwrap = 1'b1;
			return 64'd0 - mag;
		end
		if (mag > MAX_MANT)
			mwrap = 1'b1;
		return mag;
	endfunction

	function automatic dec_res_t decimal_result(input cmd_t op, input logic [63:0] am,
		input logic signed [7:0] ae, input logic [63:0] bm, input logic signed [7:0] be);
		dec_res_t r;
		logic neg[2];
		logic [63:0] mag[2];
		int ex[2];
		int big, sml, e_out;
		logic mwrap, ewrap, rneg;
		logic [64:0] sum;
		logic [63:0] rmag;
		mwrap = 1'b0;
		ewrap = 1'b0;
		neg[0] = am[63];
		neg[1] = bm[63];
		mag[0] = magnitude(am);
		mag[1] = magnitude(bm);
		ex[0] = ae;
		ex[1] = be;
		r.st = ST_OK;
		if (op == CMD_ADD || op == CMD_SUB) begin
			if (op == CMD_SUB)
				neg[1] = ~neg[1];
			if (ex[0] > ex[1] || (ex[0] == ex[1] && mag[0] > mag[1])) begin
				big = 0; sml = 1;
			end else begin
				big = 1; sml = 0;
			end
			while (mag[big] < ADD_SCALE_LIMIT && ex[big] > -100) begin
				mag[big] = mag[big] * 64'd10;
				ex[big]--;
			end
			while (ex[sml] < ex[big]) begin
				mag[sml] = mag[sml] / 64'd10;
				ex[sml]++;
			end
			while (ex[sml] > ex[big]) begin
				if (mag[sml] > WRAP_LIM)
					mwrap = 1'b1;
				mag[sml] = mag[sml] * 64'd10;
				ex[sml]--;
			end
			if (neg[0] == neg[1]) begin
				sum = {1'b0, mag[0]} + {1'b0, mag[1]};
				if (sum[64])
					mwrap = 1'b1;
				rmag = sum[63:0];
				rneg = neg[0];
			end else if (mag[0] >= mag[1]) begin
				rmag = mag[0] - mag[1];
				rneg = neg[0];
			end else begin
				rmag = mag[1] - mag[0];
				rneg = neg[1];
			end
			e_out = ex[big];
		end else if (op == CMD_MUL) begin
			for (int k = 0; k < 2; k++)
				while (mag[k] > MUL_DIGIT_MAX) begin
					mag[k] = (mag[k] + 64'd5) / 64'd10;
					ex[k]++;
				end
			rmag = mag[0] * mag[1];
			rneg = neg[0] ^ neg[1];
			e_out = ex[0] + ex[1];
		end else begin
			if (mag[1] == 64'd0) begin
				r.mant = '0;
				r.expo = '0;
				r.st = ST_DIV0;
				return r;
			end
			while (mag[0] < DIV_SCALE_LIMIT && ex[0] > -99) begin
				mag[0] = mag[0] * 64'd10;
				ex[0]--;
			end
			rmag = mag[0] / mag[1];
			rneg = neg[0] ^ neg[1];
			e_out = ex[0] - ex[1];
		end
		r.mant = signed_mant(rneg, rmag, mwrap);
		if (e_out < -128 || e_out > 127)
			ewrap = 1'b1;
		r.expo = e_out[7:0];
		if (mwrap)
			r.st = ST_MWRAP;
		else if (ewrap)
			r.st = ST_EWRAP;
		return r;
	endfunction

	// one request; valid stays high into the next request unless a gap is due
	task automatic send_req(input cmd_t op, input logic [63:0] am, input logic signed [7:0] ae,
		input logic [63:0] bm, input logic signed [7:0] be);
		in_valid <= 1'b1;
		cmd <= op;
		a_mant <= am;
		a_exp <= ae;
		b_mant <= bm;
		b_exp <= be;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(decimal_result(op, am, ae, bm, be));
		n_sent++;
		if (--burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	endtask

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		dec_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing pending: mant %0d exp %0d status %0d",
					$time, res_mant, res_exp, status);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (status == ST_MWRAP || status == ST_EWRAP)
					n_wraps++;
				if (res_mant !== want.mant) begin
					$display("%0t: res_mant expected %0d actual %0d", $time, want.mant,
						res_mant);
					n_errors++;
				end
				if (res_exp !== want.expo) begin
					$display("%0t: res_exp expected %0d actual %0d", $time, want.expo,
						res_exp);
					n_errors++;
				end
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					n_errors++;
				end
			end
		end
		stall_phase++;
		if (stall_phase >= 97) begin
			stall_phase = 0;
			stall_mode = $urandom_range(0, 2);
		end
		if (hold_off > 0) begin
			hold_off--;
			out_stall <= 1'b1;
		end else if (stall_mode == 1)
			out_stall <= ($urandom_range(0, 2) == 0);
		else if (stall_mode == 2)
			out_stall <= (stall_phase % 7) < 3;
		else
			out_stall <= 1'b0;
	end

	function automatic logic [63:0] rand_mant();
		logic [63:0] v;
		v = {$urandom, $urandom};
		if ($urandom_range(0, 3) != 0)
			v = v >> $urandom_range(0, 63);
		if ($urandom_range(0, 1))
			v = 64'd0 - v;
		return v;
	endfunction

	function automatic logic [7:0] rand_exp();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom);
		return 8'($signed($urandom_range(0, 40)) - 20);
	endfunction

	task automatic test_each_operation();
		send_req(CMD_ADD, 64'd123, 8'sd2, 64'd456, -8'sd1);
		send_req(CMD_SUB, 64'd1000, 8'sd0, 64'd1, 8'sd3);
		send_req(CMD_MUL, -64'sd12345, 8'sd4, 64'd678, -8'sd2);
		send_req(CMD_DIV, 64'd1, 8'sd0, 64'd3, 8'sd0);
		send_req(CMD_DIV, -64'sd22, 8'sd1, -64'sd7, 8'sd0);
	endtask

	task automatic test_special_cases();
		// most negative mantissa, also through subtract
		send_req(CMD_ADD, MIN_MANT, 8'sd0, 64'd1, 8'sd0);
		send_req(CMD_SUB, 64'd0, 8'sd0, MIN_MANT, 8'sd0);
		send_req(CMD_MUL, MIN_MANT, -8'sd128, MIN_MANT, -8'sd128);
		send_req(CMD_DIV, MIN_MANT, 8'sd127, 64'd1, -8'sd128);
		// mantissa wraps on sum; a tiny operand aligned to a huge one
		send_req(CMD_ADD, MAX_MANT, 8'sd0, MAX_MANT, 8'sd0);
		send_req(CMD_ADD, MAX_MANT, -8'sd128, 64'd5, -8'sd128);
		send_req(CMD_ADD, 64'd1, -8'sd100, MAX_MANT, 8'sd127);
		// exponent wraps
		send_req(CMD_MUL, 64'd9, 8'sd127, 64'd9, 8'sd127);
		send_req(CMD_DIV, 64'd1, -8'sd128, 64'd1, 8'sd127);
		// divide by zero, zero results, extreme exponent spread
		send_req(CMD_DIV, 64'd77, 8'sd5, 64'd0, -8'sd3);
		send_req(CMD_SUB, -64'sd500, 8'sd2, -64'sd500, 8'sd2);
		send_req(CMD_MUL, 64'd0, 8'sd0, -64'sd9, 8'sd1);
		send_req(CMD_ADD, MAX_MANT, 8'sd127, MIN_MANT, -8'sd128);
		send_req(CMD_SUB, 64'd5, -8'sd128, 64'd5, 8'sd127);
		send_req(CMD_DIV, 64'd0, 8'sd0, MAX_MANT, 8'sd0);
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++)
			send_req(cmd_t'($urandom_range(0, 3)), rand_mant(), rand_exp(), rand_mant(),
				rand_exp());
	endtask

	// receiver holds off while requests keep coming
	task automatic test_backpressure();
		hold_off = 400;
		test_random(10);
	endtask

	initial begin
		in_valid = 1'b0;
		cmd = CMD_ADD;
		a_mant = '0;
		a_exp = '0;
		b_mant = '0;
		b_exp = '0;
		out_stall = 1'b0;
		n_errors = 0;
		n_checked = 0;
		n_sent = 0;
		n_wraps = 0;
		burst_left = 4;
		hold_off = 0;
		stall_mode = 0;
		stall_phase = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_each_operation();
		test_special_cases();
		test_backpressure();
		test_random(340);
		test_backpressure();
		test_random(340);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("sent %0d requests, checked %0d results, %0d of them with a wrap status",
			n_sent, n_checked, n_wraps);
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#200ms;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("CHECK FAILED");
		$finish;
	end
endmodule
